// File: rtl/psi_pkg.sv
// Shared types and constants for the polygon segment intersection block.
// Holds the controller states, datapath commands and their command/status structs.
// No dependencies.
package psi_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int ADDR_W       = 4;
   localparam int CNT_W        = 5;
   localparam int COORD_W      = 32;
   localparam int DIFF_W       = 33;
   localparam int PROD_W       = 66;
   localparam int WIDE_W       = 68;
   localparam int ACC_W        = 101;
   localparam int QUO_W        = 34;
   localparam int FIX_W        = 36;
   localparam int STEP_W       = 6;
   localparam int DIV_STEPS    = 34;

   localparam logic [1:0] X_DEN = 2'd0;
   localparam logic [1:0] X_TN  = 2'd1;
   localparam logic [1:0] X_UN  = 2'd2;

   localparam logic [1:0] CHUNK_HI  = 2'd2;
   localparam logic [1:0] CHUNK_MID = 2'd1;
   localparam logic [1:0] CHUNK_LO  = 2'd0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_DIFF,
      S_XMUL,
      S_XSUB,
      S_NORM,
      S_CHECK,
      S_NMUL,
      S_NACC,
      S_DABS,
      S_DIV,
      S_PUSH,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WRITE,
      OP_LOAD,
      OP_RDA,
      OP_RDB,
      OP_DIFF,
      OP_XMUL,
      OP_XSUB,
      OP_NORM,
      OP_NMUL,
      OP_NACC,
      OP_DABS,
      OP_DIV,
      OP_PUSH,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [1:0]          sel;
   } cmd_type;

   typedef struct packed {
      logic edge_ok;
   } status_type;

endpackage

// File: rtl/psi_ctrl.sv
// Controller for the polygon segment intersection block.
// Sequences the edge walk and issues commands to psi_datapath; depends on psi_pkg.
module psi_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_func,
   input  logic                      csr_wr_en,
   input  logic [psi_pkg::CNT_W-1:0] csr_wr_data,
   input  psi_pkg::status_type       status,
   output logic                      busy,
   output psi_pkg::cmd_type          cmd
);
   import psi_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    edge_ff, edge_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    num_edges;
   logic [CNT_W-1:0]    edge_next;
   logic [ADDR_W-1:0]   next_addr;
   logic                last_edge;

   assign num_edges = (count_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_ff;
   assign edge_next = edge_ff + 1'b1;
   assign last_edge = (edge_next == num_edges);
   assign next_addr = last_edge ? '0 : edge_next[ADDR_W-1:0];
   assign busy      = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         edge_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
         step_ff  <= step_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      edge_in  = edge_ff;
      step_in  = step_ff;
      cmd.op   = OP_NOP;
      cmd.addr = edge_ff[ADDR_W-1:0];
      cmd.sel  = step_ff[1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (!req_func) begin
                  cmd.op = OP_WRITE;
               end else begin
                  cmd.op   = OP_LOAD;
                  edge_in  = '0;
                  state_in = (num_edges == '0) ? S_FINISH : S_RD_A;
               end
            end
         end
         S_RD_A: begin
            cmd.op   = OP_RDA;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            cmd.op   = OP_RDB;
            cmd.addr = next_addr;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            step_in  = '0;
            state_in = S_XMUL;
         end
         S_XMUL: begin
            cmd.op   = OP_XMUL;
            state_in = S_XSUB;
         end
         S_XSUB: begin
            cmd.op = OP_XSUB;
            if (step_ff[1:0] == X_UN) begin
               state_in = S_NORM;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_XMUL;
            end
         end
         S_NORM: begin
            cmd.op   = OP_NORM;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.edge_ok) begin
               step_in  = STEP_W'(CHUNK_HI);
               state_in = S_NMUL;
            end else begin
               edge_in  = edge_next;
               state_in = last_edge ? S_FINISH : S_RD_A;
            end
         end
         S_NMUL: begin
            cmd.op   = OP_NMUL;
            state_in = S_NACC;
         end
         S_NACC: begin
            cmd.op = OP_NACC;
            if (step_ff[1:0] == CHUNK_LO) begin
               state_in = S_DABS;
            end else begin
               step_in  = step_ff - 1'b1;
               state_in = S_NMUL;
            end
         end
         S_DABS: begin
            cmd.op   = OP_DABS;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_PUSH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_PUSH: begin
            cmd.op   = OP_PUSH;
            edge_in  = edge_next;
            state_in = last_edge ? S_FINISH : S_RD_A;
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   property p_div_bound;
      @(posedge clock) disable iff (reset)
         state_ff == S_DIV |-> step_ff < STEP_W'(DIV_STEPS);
   endproperty
   assert property (p_div_bound) else $error("divider step count overran");

   property p_edge_bound;
      @(posedge clock) disable iff (reset)
         state_ff != S_IDLE && state_ff != S_FINISH |-> edge_ff < num_edges;
   endproperty
   assert property (p_edge_bound) else $error("edge walk passed the vertex count");

   property p_finish_idle;
      @(posedge clock) disable iff (reset)
         state_ff == S_FINISH |=> !busy;
   endproperty
   assert property (p_finish_idle) else $error("query did not end after finish");

endmodule

// File: rtl/psi_datapath.sv
// Datapath for the polygon segment intersection block: vertex memory,
// cross products, range check, radix-2 dividers and result register; depends on psi_pkg.
module psi_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  psi_pkg::cmd_type                    cmd,
   input  logic [psi_pkg::ADDR_W-1:0]          req_vertex_index,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_start_y,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_end_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_end_y,
   output psi_pkg::status_type                 status,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [psi_pkg::ADDR_W-1:0]          rsp_edge_index,
   output logic signed [psi_pkg::COORD_W-1:0]  rsp_hit_x,
   output logic signed [psi_pkg::COORD_W-1:0]  rsp_hit_y,
   output logic                                rsp_last
);
   import psi_pkg::*;

   logic [2*COORD_W-1:0]        mem [MAX_VERTICES];
   logic [2*COORD_W-1:0]        rd_ff;

   logic signed [COORD_W-1:0]   px_ff, py_ff, ax_ff, ay_ff;
   logic signed [DIFF_W-1:0]    rx_ff, ry_ff, sx_ff, sy_ff, qx_ff, qy_ff;
   logic [ADDR_W-1:0]           edge_ff;
   logic signed [PROD_W-1:0]    m1_ff, m2_ff, m1_in, m2_in;
   logic signed [DIFF_W-1:0]    a1, b1, a2, b2;
   logic [COORD_W-1:0]          chunk;
   logic signed [WIDE_W-1:0]    den_ff, tn_ff, un_ff, cross_in;
   logic signed [ACC_W-1:0]     accx_ff, accy_ff, accx_in, accy_in;
   logic [ACC_W-1:0]            absx, absy;
   logic                        negx_ff, negy_ff;
   logic [WIDE_W-1:0]           remx_ff, remy_ff, remx_in, remy_in;
   logic [QUO_W-1:0]            lox_ff, loy_ff, lox_in, loy_in;
   logic [WIDE_W:0]             tx, ty, dx, dy, den_ext;
   logic                        gex, gey;
   logic signed [FIX_W-1:0]     qsx, qsy, sumx, sumy, finx, finy;
   logic                        nzx, nzy;
   logic                        pend_v_ff;
   logic [ADDR_W-1:0]           pend_edge_ff;
   logic signed [COORD_W-1:0]   pend_x_ff, pend_y_ff;
   logic                        rsp_valid_ff;

   always_comb begin
      a1    = '0;
      b1    = '0;
      a2    = '0;
      b2    = '0;
      chunk = '0;
      case (cmd.sel)
         CHUNK_HI:  chunk = COORD_W'(tn_ff[WIDE_W-1:2*COORD_W]);
         CHUNK_MID: chunk = tn_ff[2*COORD_W-1:COORD_W];
         default:   chunk = tn_ff[COORD_W-1:0];
      endcase
      case (cmd.op)
         OP_XMUL: begin
            case (cmd.sel)
               X_DEN: begin
                  a1 = rx_ff; b1 = sy_ff; a2 = ry_ff; b2 = sx_ff;
               end
               X_TN: begin
                  a1 = qx_ff; b1 = sy_ff; a2 = qy_ff; b2 = sx_ff;
               end
               default: begin
                  a1 = qx_ff; b1 = ry_ff; a2 = qy_ff; b2 = rx_ff;
               end
            endcase
         end
         OP_NMUL: begin
            a1 = rx_ff;
            b1 = $signed({1'b0, chunk});
            a2 = ry_ff;
            b2 = $signed({1'b0, chunk});
         end
         default: begin
         end
      endcase
   end

   assign m1_in    = a1 * b1;
   assign m2_in    = a2 * b2;
   assign cross_in = WIDE_W'(m1_ff) - WIDE_W'(m2_ff);

   assign status.edge_ok = (den_ff != '0) && !tn_ff[WIDE_W-1] && (tn_ff <= den_ff)
                           && !un_ff[WIDE_W-1] && (un_ff <= den_ff);

   assign accx_in = (cmd.sel == CHUNK_HI) ? ACC_W'(m1_ff)
                                          : (accx_ff <<< COORD_W) + ACC_W'(m1_ff);
   assign accy_in = (cmd.sel == CHUNK_HI) ? ACC_W'(m2_ff)
                                          : (accy_ff <<< COORD_W) + ACC_W'(m2_ff);
   assign absx    = accx_ff[ACC_W-1] ? ACC_W'(-accx_ff) : ACC_W'(accx_ff);
   assign absy    = accy_ff[ACC_W-1] ? ACC_W'(-accy_ff) : ACC_W'(accy_ff);

   assign den_ext = {1'b0, den_ff};
   assign tx      = {remx_ff, lox_ff[QUO_W-1]};
   assign ty      = {remy_ff, loy_ff[QUO_W-1]};
   assign dx      = tx - den_ext;
   assign dy      = ty - den_ext;
   assign gex     = (tx >= den_ext);
   assign gey     = (ty >= den_ext);
   assign remx_in = gex ? dx[WIDE_W-1:0] : tx[WIDE_W-1:0];
   assign remy_in = gey ? dy[WIDE_W-1:0] : ty[WIDE_W-1:0];
   assign lox_in  = {lox_ff[QUO_W-2:0], gex};
   assign loy_in  = {loy_ff[QUO_W-2:0], gey};

   assign nzx  = (remx_ff != '0);
   assign nzy  = (remy_ff != '0);
   assign qsx  = negx_ff ? (nzx ? $signed(~FIX_W'(lox_ff)) : -$signed(FIX_W'(lox_ff)))
                         : $signed(FIX_W'(lox_ff));
   assign qsy  = negy_ff ? (nzy ? $signed(~FIX_W'(loy_ff)) : -$signed(FIX_W'(loy_ff)))
                         : $signed(FIX_W'(loy_ff));
   assign sumx = FIX_W'(px_ff) + qsx;
   assign sumy = FIX_W'(py_ff) + qsy;
   assign finx = sumx + $signed(FIX_W'(sumx[FIX_W-1] && nzx));
   assign finy = sumy + $signed(FIX_W'(sumy[FIX_W-1] && nzy));

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         mem[req_vertex_index] <= {req_vertex_x, req_vertex_y};
      end
      rd_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      case (cmd.op)
         OP_LOAD: begin
            px_ff <= req_start_x;
            py_ff <= req_start_y;
            rx_ff <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
            ry_ff <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
         end
         OP_RDA: begin
            edge_ff <= cmd.addr;
         end
         OP_RDB: begin
            ax_ff <= $signed(rd_ff[2*COORD_W-1:COORD_W]);
            ay_ff <= $signed(rd_ff[COORD_W-1:0]);
         end
         OP_DIFF: begin
            sx_ff <= DIFF_W'($signed(rd_ff[2*COORD_W-1:COORD_W])) - DIFF_W'(ax_ff);
            sy_ff <= DIFF_W'($signed(rd_ff[COORD_W-1:0])) - DIFF_W'(ay_ff);
            qx_ff <= DIFF_W'(ax_ff) - DIFF_W'(px_ff);
            qy_ff <= DIFF_W'(ay_ff) - DIFF_W'(py_ff);
         end
         OP_XSUB: begin
            case (cmd.sel)
               X_DEN:   den_ff <= cross_in;
               X_TN:    tn_ff  <= cross_in;
               default: un_ff  <= cross_in;
            endcase
         end
         OP_NORM: begin
            if (den_ff[WIDE_W-1]) begin
               den_ff <= -den_ff;
               tn_ff  <= -tn_ff;
               un_ff  <= -un_ff;
            end
         end
         OP_NACC: begin
            accx_ff <= accx_in;
            accy_ff <= accy_in;
         end
         OP_DABS: begin
            negx_ff <= accx_ff[ACC_W-1];
            negy_ff <= accy_ff[ACC_W-1];
            remx_ff <= WIDE_W'(absx >> QUO_W);
            remy_ff <= WIDE_W'(absy >> QUO_W);
            lox_ff  <= absx[QUO_W-1:0];
            loy_ff  <= absy[QUO_W-1:0];
         end
         OP_DIV: begin
            remx_ff <= remx_in;
            remy_ff <= remy_in;
            lox_ff  <= lox_in;
            loy_ff  <= loy_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_LOAD: begin
               pend_v_ff <= 1'b0;
            end
            OP_PUSH: begin
               if (pend_v_ff) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_hit        <= 1'b1;
                  rsp_edge_index <= pend_edge_ff;
                  rsp_hit_x      <= pend_x_ff;
                  rsp_hit_y      <= pend_y_ff;
                  rsp_last       <= 1'b0;
               end
               pend_v_ff    <= 1'b1;
               pend_edge_ff <= edge_ff;
               pend_x_ff    <= finx[COORD_W-1:0];
               pend_y_ff    <= finy[COORD_W-1:0];
            end
            OP_FINISH: begin
               rsp_valid_ff   <= 1'b1;
               rsp_last       <= 1'b1;
               rsp_hit        <= pend_v_ff;
               rsp_edge_index <= pend_v_ff ? pend_edge_ff : '0;
               rsp_hit_x      <= pend_v_ff ? pend_x_ff : '0;
               rsp_hit_y      <= pend_v_ff ? pend_y_ff : '0;
               pend_v_ff      <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   property p_miss_is_last;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && !rsp_hit |-> rsp_last && rsp_hit_x == '0 && rsp_hit_y == '0;
   endproperty
   assert property (p_miss_is_last) else $error("no-hit transfer is not a lone final result");

   property p_push_holds;
      @(posedge clock) disable iff (reset)
         cmd.op == OP_PUSH |=> pend_v_ff;
   endproperty
   assert property (p_push_holds) else $error("intersection was not held for delivery");

   property p_finish_flush;
      @(posedge clock) disable iff (reset)
         cmd.op == OP_FINISH |=> rsp_valid_ff && rsp_last && !pend_v_ff;
   endproperty
   assert property (p_finish_flush) else $error("query end did not deliver its final transfer");

endmodule

// File: rtl/polygon_segment_intersect.sv
// Segment against polygon edge intersection, signed Q16.16, top level.
// A vertex write leaves busy low. A query holds busy while it walks the edges,
// an edge that is hit also passing through the 34-step radix-2
// divider; results trail the walk by one edge and the
// receiver cannot stall. Synchronous active-high reset clears the vertex count
// and control state; vertex table contents are undefined until written.
module polygon_segment_intersect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [psi_pkg::ADDR_W-1:0]          req_vertex_index,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_start_y,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_end_x,
   input  logic signed [psi_pkg::COORD_W-1:0]  req_end_y,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [psi_pkg::ADDR_W-1:0]          rsp_edge_index,
   output logic signed [psi_pkg::COORD_W-1:0]  rsp_hit_x,
   output logic signed [psi_pkg::COORD_W-1:0]  rsp_hit_y,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [psi_pkg::CNT_W-1:0]           csr_wr_data
);
   import psi_pkg::*;

   cmd_type    cmd;
   status_type status;

   psi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_func    (req_func),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   psi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_edge_index   (rsp_edge_index),
      .rsp_hit_x        (rsp_hit_x),
      .rsp_hit_y        (rsp_hit_y),
      .rsp_last         (rsp_last)
   );

endmodule

// File: tb/sv/tb.sv
// Testbench for polygon_segment_intersect: vertex writes and segment queries are driven
// through the start/busy port, and every result is checked against an exact predictor or a fixed expected result.
// Depends on psi_pkg and the polygon_segment_intersect RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psi_pkg::*;

   localparam logic FN_WRITE = 1'b0;
   localparam logic FN_QUERY = 1'b1;
   localparam int   STALL_LIMIT = 20000;

   typedef struct packed {
      logic              hit;
      logic [3:0]        edge_index;
      logic [31:0]       hit_x;
      logic [31:0]       hit_y;
      logic              last;
   } hit_type;

   typedef struct {
      logic              func;
      logic [3:0]        idx;
      logic [31:0]       ax;
      logic [31:0]       ay;
      logic [31:0]       bx;
      logic [31:0]       by;
      bit                typed;
      hit_type           want;
   } row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [3:0]        req_vertex_index;
   logic signed [31:0] req_vertex_x, req_vertex_y;
   logic signed [31:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic              rsp_valid, rsp_hit, rsp_last;
   logic [3:0]        rsp_edge_index;
   logic signed [31:0] rsp_hit_x, rsp_hit_y;
   logic              csr_wr_en;
   logic [4:0]        csr_wr_data;

   polygon_segment_intersect uut (.*);

   logic signed [31:0] poly_x [16];
   logic signed [31:0] poly_y [16];
   int                 poly_n;
   hit_type            pending_hits [$];
   int                 errors;
   int                 idle_cycles;
   int                 idle_pct;
   bit                 start_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [127:0] cross2(logic signed [127:0] ax, logic signed [127:0] ay,
                                                  logic signed [127:0] bx,
                                                  logic signed [127:0] by);
      return ax * by - ay * bx;
   endfunction

   function automatic void predict_query(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] ex, logic signed [31:0] ey);
      logic signed [127:0] rx, ry, sx, sy, qx, qy, den, tn, un, nx, ny, hx, hy;
      int n, j, k;
      hit_type h;
      n = poly_n > 16 ? 16 : poly_n;
      k = 0;
      rx = 128'(ex) - 128'(px);
      ry = 128'(ey) - 128'(py);
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         sx = 128'(poly_x[j]) - 128'(poly_x[i]);
         sy = 128'(poly_y[j]) - 128'(poly_y[i]);
         qx = 128'(poly_x[i]) - 128'(px);
         qy = 128'(poly_y[i]) - 128'(py);
         den = cross2(rx, ry, sx, sy);
         if (den == 0) continue;
         tn = cross2(qx, qy, sx, sy);
         un = cross2(qx, qy, rx, ry);
         if (den < 0) begin
            den = -den;
            tn = -tn;
            un = -un;
         end
         if (tn < 0 || tn > den || un < 0 || un > den) continue;
         nx = 128'(px) * den + rx * tn;
         ny = 128'(py) * den + ry * tn;
         hx = nx / den;
         hy = ny / den;
         h.hit = 1'b1;
         h.edge_index = 4'(i);
         h.hit_x = hx[31:0];
         h.hit_y = hy[31:0];
         h.last = 1'b0;
         pending_hits.push_back(h);
         k++;
      end
      if (k == 0) begin
         pending_hits.push_back('{hit: 1'b0, edge_index: 4'd0, hit_x: 32'd0, hit_y: 32'd0,
                                  last: 1'b1});
      end else begin
         h = pending_hits.pop_back();
         h.last = 1'b1;
         pending_hits.push_back(h);
      end
   endfunction

   always @(posedge clock) begin
      hit_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_hit, rsp_edge_index, rsp_hit_x, rsp_hit_y, rsp_last};
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pending_hits.pop_front();
            if (got.hit !== want.hit || got.edge_index !== want.edge_index
                || got.hit_x !== want.hit_x || got.hit_y !== want.hit_y
                || got.last !== want.last) begin
               $display("%0t: mismatch expected hit=%b edge=%0d x=%h y=%h last=%b",
                        $time, want.hit, want.edge_index, want.hit_x, want.hit_y, want.last);
               $display("%0t:          actual   hit=%b edge=%0d x=%h y=%h last=%b",
                        $time, got.hit, got.edge_index, got.hit_x, got.hit_y, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic set_vertex_count(int n);
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 5'(n);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      poly_n = n;
   endtask

   task automatic drain();
      if (start_on) begin
         start <= 1'b0;
         start_on = 1'b0;
      end
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   // One transfer; start stays high until busy is seen low at an edge, and is left
   // high so that a following transfer can go back to back.
   task automatic issue(row_type r);
      while ($urandom_range(99) < idle_pct) begin
         if (start_on) begin
            start <= 1'b0;
            start_on = 1'b0;
         end
         @(posedge clock);
      end
      req_func <= r.func;
      req_vertex_index <= r.idx;
      req_vertex_x <= r.ax;
      req_vertex_y <= r.ay;
      req_start_x <= r.ax;
      req_start_y <= r.ay;
      req_end_x <= r.bx;
      req_end_y <= r.by;
      start <= 1'b1;
      start_on = 1'b1;
      do @(posedge clock); while (busy);
      if (r.func == FN_WRITE) begin
         poly_x[r.idx] = r.ax;
         poly_y[r.idx] = r.ay;
      end else if (r.typed) begin
         pending_hits.push_back(r.want);
      end else begin
         predict_query(r.ax, r.ay, r.bx, r.by);
      end
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(4))
         0: return $urandom();
         1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return 32'($signed($urandom_range(40)) - 20) <<< 16;
      endcase
   endfunction

   function automatic row_type vertex_row(int i, logic [31:0] x, logic [31:0] y);
      row_type r;
      r = '{func: FN_WRITE, idx: 4'(i), ax: x, ay: y, bx: 0, by: 0, typed: 0, want: '0};
      return r;
   endfunction

   function automatic row_type query_row(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                                         logic [31:0] by);
      row_type r;
      r = '{func: FN_QUERY, idx: 4'($urandom()), ax: ax, ay: ay, bx: bx, by: by, typed: 0,
            want: '0};
      return r;
   endfunction

   localparam hit_type NO_HIT = '{1'b0, 4'd0, 32'd0, 32'd0, 1'b1};
   localparam logic [31:0] MAXC = 32'h7fffffff;
   localparam logic [31:0] MINC = 32'h80000000;
   localparam logic [31:0] ONE  = 32'h00010000;

   initial begin
      row_type rows [$];
      row_type r;
      int phase_n;
      errors = 0;
      poly_n = 0;
      idle_pct = 0;
      start_on = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FN_WRITE;
      req_vertex_index <= '0;
      req_vertex_x <= '0;
      req_vertex_y <= '0;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x <= '0;
      req_end_y <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: no edges after reset, a square, extremes, degenerate cases.
      r = query_row(0, 0, ONE, ONE);
      r.typed = 1;
      r.want = NO_HIT;
      rows.push_back(r);
      rows.push_back(vertex_row(0, 0, 0));
      rows.push_back(vertex_row(1, 4 * ONE, 0));
      rows.push_back(vertex_row(2, 4 * ONE, 4 * ONE));
      rows.push_back(vertex_row(3, 0, 4 * ONE));
      rows.push_back(vertex_row(15, MINC, MAXC));
      foreach (rows[i]) issue(rows[i]);
      rows.delete();
      drain();
      set_vertex_count(1);
      r = query_row(MINC, MINC, MAXC, MAXC);
      r.typed = 1;
      r.want = NO_HIT;
      issue(r);
      drain();
      set_vertex_count(4);
      rows.push_back(query_row(-ONE, 2 * ONE, 5 * ONE, 2 * ONE));
      rows.push_back(query_row(2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
      rows.push_back(query_row(0, 0, 4 * ONE, 4 * ONE));
      rows.push_back(query_row(0, -ONE, 0, 5 * ONE));
      rows.push_back(query_row(MINC, MINC, MAXC, MAXC));
      rows.push_back(query_row(MAXC, MINC, MINC, MAXC));
      rows.push_back(query_row(-ONE, ONE, 5 * ONE, 3 * ONE + 7));
      rows.push_back(query_row(ONE, ONE, 3 * ONE, 3 * ONE));
      foreach (rows[i]) issue(rows[i]);
      rows.delete();
      drain();
      for (int i = 4; i < 16; i++) issue(vertex_row(i, rand_coord(), rand_coord()));
      drain();
      set_vertex_count(31);
      issue(query_row(MINC, MAXC, MAXC, MINC));
      drain();

      // Random part in phases with different sender idling and polygon sizes.
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 47;
            2: idle_pct = 10;
            default: idle_pct = 47;
         endcase
         phase_n = (p == 7) ? 16 : $urandom_range(16, 2);
         drain();
         set_vertex_count(phase_n);
         for (int k = 0; k < 17; k++) begin
            if ($urandom_range(3) == 0)
               issue(vertex_row($urandom_range(15), rand_coord(), rand_coord()));
            else
               issue(query_row(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
         end
      end
      drain();
      repeat (900) @(posedge clock);
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/psi_pkg.sv
rtl/psi_ctrl.sv
rtl/psi_datapath.sv
rtl/polygon_segment_intersect.sv
tb/sv/tb.sv
